FILE: design/asp_pkg.sv
// ----------------------------------------------------------------------------
// asp_pkg: shared types and constants of the arcsinh stretch pipeline
// Many widths follow from SAMPLE_BITS and ASINH_STAGES; the others are fixed.
// ----------------------------------------------------------------------------
package asp_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int ASINH_STAGES = 20;

    localparam int SW    = SAMPLE_BITS + 1;       // sample width
    localparam int BLW   = 16;                    // black level register
    localparam int SFW   = 18;                    // stretch factor register
    localparam int GW    = 11;                    // gain register
    localparam int CIW   = 2;                     // config index
    localparam int QW    = SAMPLE_BITS + 21;      // quotient x, Q.20
    localparam int DW    = SW;                    // divisor width
    localparam int RW    = DW + 1;                // partial remainder
    localparam int XLO   = 19;                    // split of x for the multiply
    localparam int XHI   = QW - XLO;
    localparam int YW    = QW + SFW - 8;          // y = x * beta, Q.20
    localparam int YCW   = (YW > 41) ? YW : 41;
    localparam int SQB   = 21;                    // root digits
    localparam int SQIW  = 5;                     // root digit index
    localparam int RMW   = 41;                    // root residual
    localparam int TW    = 62;                    // root trial term
    localparam int WW    = YCW + 2;               // w = y + sqrt(y^2 + 1)
    localparam int LZB   = $clog2(WW);
    localparam int MW    = 31;                    // Q.30 mantissa
    localparam int LGW   = LZB + ASINH_STAGES;
    localparam int LPW   = LGW + 24;
    localparam int AW    = LPW - (ASINH_STAGES + 4);
    localparam int IW    = 24;                    // inv_norm width
    localparam int M1W   = AW + IW;
    localparam int PW    = M1W + GW;
    localparam int OSH   = 48 - SAMPLE_BITS;
    localparam int BP_LSH = (SAMPLE_BITS >= 16) ? SAMPLE_BITS - 16 : 0;
    localparam int BP_RSH = (SAMPLE_BITS >= 16) ? 0 : 16 - SAMPLE_BITS;
    localparam int RQW   = 41;                    // 2^40 / a quotient
    localparam int RCW   = 6;
    localparam int LAT   = QW + 2 + SQB + LZB + ASINH_STAGES + 5;  // row depth
    localparam int OCW   = $clog2(LAT + 1);       // requests in flight

    localparam logic [SW-1:0] ONE_S   = SW'(1) << SAMPLE_BITS;
    localparam logic [23:0]   LN2_Q24 = 24'd11629080;
    localparam logic [IW-1:0] INV_MAX = '1;
    localparam logic [IW-1:0] INV_ONE = IW'(1) << 20;

    typedef enum logic [1:0] {
        KIND_CALC,
        KIND_ZERO,
        KIND_ONE
    } kind_t;

    typedef enum logic [CIW-1:0] {
        REG_BLACK,
        REG_STRETCH,
        REG_GAIN
    } reg_idx_t;

    typedef struct packed {
        logic            is_norm;   // beta normalization token, no result
        kind_t           kind;
        logic            low_log;   // w below 1.0, asinh is 0
        logic [LZB-1:0]  ipart;     // integer part of log2(w)
    } side_t;

endpackage

FILE: design/asp_div_cell.sv
// ----------------------------------------------------------------------------
// asp_div_cell: one quotient bit of the pipelined restoring divider
// Shifts in one dividend bit, subtracts the divisor when it fits.
// ----------------------------------------------------------------------------
module asp_div_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   valid_in,
    input  asp_pkg::side_t         side_in,
    input  logic [asp_pkg::QW-1:0] num_in,
    input  logic [asp_pkg::DW-1:0] den_in,
    input  logic [asp_pkg::RW-1:0] rem_in,
    input  logic [asp_pkg::QW-1:0] quo_in,
    output logic                   valid_out,
    output asp_pkg::side_t         side_out,
    output logic [asp_pkg::QW-1:0] num_out,
    output logic [asp_pkg::DW-1:0] den_out,
    output logic [asp_pkg::RW-1:0] rem_out,
    output logic [asp_pkg::QW-1:0] quo_out
);
    import asp_pkg::*;

    logic          valid_reg;
    side_t         side_reg;
    logic [QW-1:0] num_reg, num_next;
    logic [DW-1:0] den_reg;
    logic [RW-1:0] rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [RW-1:0] sh;
    logic          ge;

    always_comb
    begin
        sh       = {rem_in[RW-2:0], num_in[QW-1]};
        ge       = (sh >= {1'b0, den_in});
        rem_next = ge ? (sh - {1'b0, den_in}) : sh;
        quo_next = {quo_in[QW-2:0], ge};
        num_next = {num_in[QW-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_in;
            num_reg  <= num_next;
            den_reg  <= den_in;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

    assign valid_out = valid_reg;
    assign side_out  = side_reg;
    assign num_out   = num_reg;
    assign den_out   = den_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;

endmodule

FILE: design/asp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// asp_sqrt_cell: one digit of d = sqrt(y^2 + 1) - y
// Keeps R = 2^40 - d*(2y + d); a digit is taken when its increment fits in R.
// ----------------------------------------------------------------------------
module asp_sqrt_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic [asp_pkg::SQIW-1:0] bit_idx,
    input  logic                     valid_in,
    input  asp_pkg::side_t           side_in,
    input  logic [asp_pkg::YCW-1:0]  y_in,
    input  logic [asp_pkg::SQB-1:0]  d_in,
    input  logic [asp_pkg::RMW-1:0]  r_in,
    output logic                     valid_out,
    output asp_pkg::side_t           side_out,
    output logic [asp_pkg::YCW-1:0]  y_out,
    output logic [asp_pkg::SQB-1:0]  d_out,
    output logic [asp_pkg::RMW-1:0]  r_out
);
    import asp_pkg::*;

    logic           valid_reg;
    side_t          side_reg;
    logic [YCW-1:0] y_reg;
    logic [SQB-1:0] d_reg, d_next;
    logic [RMW-1:0] r_reg, r_next;
    logic [TW-1:0]  term;
    logic           big;
    logic           take;

    always_comb
    begin
        // y at or above 2^40 never admits a digit
        big    = |y_in[YCW-1:40];
        term   = ((TW'(y_in[39:0]) << 1) + (TW'(d_in) << 1) + (TW'(1) << bit_idx)) << bit_idx;
        take   = !big && (term <= TW'(r_in));
        d_next = take ? (d_in | (SQB'(1) << bit_idx)) : d_in;
        r_next = take ? (r_in - term[RMW-1:0]) : r_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_in;
            y_reg    <= y_in;
            d_reg    <= d_next;
            r_reg    <= r_next;
        end
    end

    assign valid_out = valid_reg;
    assign side_out  = side_reg;
    assign y_out     = y_reg;
    assign d_out     = d_reg;
    assign r_out     = r_reg;

endmodule

FILE: design/asp_norm_cell.sv
// ----------------------------------------------------------------------------
// asp_norm_cell: one step of the leading-one normalizer
// Shifts left by its amount when the top bits are all zero, counts the shift.
// ----------------------------------------------------------------------------
module asp_norm_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic [asp_pkg::LZB-1:0] shamt,
    input  logic                    valid_in,
    input  asp_pkg::side_t          side_in,
    input  logic [asp_pkg::WW-1:0]  word_in,
    input  logic [asp_pkg::LZB-1:0] lz_in,
    output logic                    valid_out,
    output asp_pkg::side_t          side_out,
    output logic [asp_pkg::WW-1:0]  word_out,
    output logic [asp_pkg::LZB-1:0] lz_out
);
    import asp_pkg::*;

    logic           valid_reg;
    side_t          side_reg;
    logic [WW-1:0]  word_reg, word_next;
    logic [LZB-1:0] lz_reg, lz_next;
    logic           top_zero;

    always_comb
    begin
        top_zero  = ((word_in >> (WW - int'(shamt))) == '0);
        word_next = top_zero ? (word_in << shamt) : word_in;
        lz_next   = top_zero ? (lz_in + shamt) : lz_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_in;
            word_reg <= word_next;
            lz_reg   <= lz_next;
        end
    end

    assign valid_out = valid_reg;
    assign side_out  = side_reg;
    assign word_out  = word_reg;
    assign lz_out    = lz_reg;

endmodule

FILE: design/asp_log_cell.sv
// ----------------------------------------------------------------------------
// asp_log_cell: one fraction bit of log2 by squaring the mantissa
// Squares a Q.30 mantissa in [1,2); a square of 2 or more gives a one bit.
// ----------------------------------------------------------------------------
module asp_log_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             valid_in,
    input  asp_pkg::side_t                   side_in,
    input  logic [asp_pkg::MW-1:0]           m_in,
    input  logic [asp_pkg::ASINH_STAGES-1:0] f_in,
    output logic                             valid_out,
    output asp_pkg::side_t                   side_out,
    output logic [asp_pkg::MW-1:0]           m_out,
    output logic [asp_pkg::ASINH_STAGES-1:0] f_out
);
    import asp_pkg::*;

    logic                    valid_reg;
    side_t                   side_reg;
    logic [MW-1:0]           m_reg, m_next;
    logic [ASINH_STAGES-1:0] f_reg, f_next;
    logic [2*MW-1:0]         sq;
    logic [MW:0]             sq_q30;

    always_comb
    begin
        sq     = m_in * m_in;
        sq_q30 = sq[2*MW-1:30];
        m_next = sq_q30[MW] ? sq_q30[MW:1] : sq_q30[MW-1:0];
        f_next = {f_in[ASINH_STAGES-2:0], sq_q30[MW]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_in;
            m_reg    <= m_next;
            f_reg    <= f_next;
        end
    end

    assign valid_out = valid_reg;
    assign side_out  = side_reg;
    assign m_out     = m_reg;
    assign f_out     = f_reg;

endmodule

FILE: design/asp_recip.sv
// ----------------------------------------------------------------------------
// asp_recip: normalization reciprocal 2^40 / asinh(beta)
// Serial restoring divider, one quotient bit per cycle, holds inv_norm.
// ----------------------------------------------------------------------------
module asp_recip (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [asp_pkg::AW-1:0] a_in,
    output logic                   busy,
    output logic [asp_pkg::IW-1:0] inv_norm
);
    import asp_pkg::*;

    logic            busy_reg, busy_next;
    logic [RCW-1:0]  cnt_reg, cnt_next;
    logic [AW-1:0]   den_reg;
    logic [AW-1:0]   rem_reg, rem_next;
    logic [RQW-1:0]  quo_reg, quo_next;
    logic [IW-1:0]   inv_reg, inv_next;
    logic            inv_load;
    logic [AW:0]     sh;
    logic            ge;

    always_comb
    begin
        sh        = {rem_reg, (cnt_reg == RCW'(RQW - 1))};
        ge        = (sh >= {1'b0, den_reg});
        rem_next  = ge ? AW'(sh - {1'b0, den_reg}) : sh[AW-1:0];
        quo_next  = {quo_reg[RQW-2:0], ge};
        cnt_next  = cnt_reg - RCW'(1);
        busy_next = busy_reg;
        inv_load  = 1'b0;
        inv_next  = inv_reg;
        if (start)
        begin
            if (a_in == '0)
            begin
                inv_load = 1'b1;
                inv_next = INV_ONE;
            end
            else
                busy_next = 1'b1;
        end
        else if (busy_reg && (cnt_reg == '0))
        begin
            busy_next = 1'b0;
            inv_load  = 1'b1;
            inv_next  = (quo_next > RQW'(INV_MAX)) ? INV_MAX : quo_next[IW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= a_in;
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= RCW'(RQW - 1);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_next;
        end
        if (inv_load)
            inv_reg <= inv_next;
    end

    assign busy     = busy_reg;
    assign inv_norm = inv_reg;

endmodule

FILE: design/asinh_stretch_pixel.sv
// ----------------------------------------------------------------------------
// asinh_stretch_pixel: arcsinh stretch of a pixel sample stream
// Divider, root, normalizer and log cells in one row, then scaling multiplies.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle; the whole row stalls with the output.
// Config waits for an empty row; a pending config request holds off samples.
// After reset and after each stretch_factor write, inputs and config are stalled
// until the beta token reaches the reciprocal unit and its divide is done.
module asinh_stretch_pixel (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [asp_pkg::SW-1:0]  sample_in,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [asp_pkg::SW-1:0]  sample_out,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [asp_pkg::CIW-1:0] cfg_index,
    input  logic [asp_pkg::SFW-1:0] cfg_data
);
    import asp_pkg::*;

    // configuration
    logic [BLW-1:0] black_reg;
    logic [SFW-1:0] stretch_reg;
    logic [GW-1:0]  gain_reg;
    logic           cfg_wr;

    // control
    logic adv, accept, inject, norm_busy, recip_busy, recip_start;
    logic pend_reg, pend_next, inflight_reg, inflight_next;
    logic [IW-1:0] inv_norm;
    logic           out_take;
    logic [OCW-1:0] occ_reg, occ_next;

    // front end
    logic [SAMPLE_BITS+15:0] bp_wide;
    logic [SAMPLE_BITS-1:0]  bp;
    logic [SW-1:0]           diff;
    side_t                   side0;
    logic [QW-1:0]           num0;
    logic [DW-1:0]           den0;

    // divider row
    logic          dv_valid [0:QW];
    side_t         dv_side  [0:QW];
    logic [QW-1:0] dv_num   [0:QW];
    logic [DW-1:0] dv_den   [0:QW];
    logic [RW-1:0] dv_rem   [0:QW];
    logic [QW-1:0] dv_quo   [0:QW];

    // multiply by beta
    logic               m1_valid_reg, m2_valid_reg;
    side_t              m1_side_reg, m2_side_reg;
    logic [XLO+SFW-1:0] plo_reg;
    logic [XHI+SFW-1:0] phi_reg;
    logic [YW-1:0]      y_reg;
    logic [YW+8:0]      y_full;

    // root row
    logic           sq_valid [0:SQB];
    side_t          sq_side  [0:SQB];
    logic [YCW-1:0] sq_y     [0:SQB];
    logic [SQB-1:0] sq_d     [0:SQB];
    logic [RMW-1:0] sq_r     [0:SQB];

    // normalizer row
    logic           nm_valid [0:LZB];
    side_t          nm_side  [0:LZB];
    logic [WW-1:0]  nm_word  [0:LZB];
    logic [LZB-1:0] nm_lz    [0:LZB];
    logic [LZB-1:0] msb_pos;

    // log row
    logic                    lg_valid [0:ASINH_STAGES];
    side_t                   lg_side  [0:ASINH_STAGES];
    logic [MW-1:0]           lg_m     [0:ASINH_STAGES];
    logic [ASINH_STAGES-1:0] lg_f     [0:ASINH_STAGES];
    side_t                   lg_side0;

    // scaling
    logic          f1_valid_reg, f2_valid_reg, f3_valid_reg, f4_valid_reg;
    side_t         f1_side_reg, f2_side_reg, f3_side_reg, f4_side_reg;
    logic [LPW-1:0] lp_reg;
    logic [AW-1:0]  a_reg;
    logic [M1W-1:0] m1p_reg;
    logic [PW-1:0]  m2p_reg;
    logic [PW-OSH-1:0] r_scaled;
    logic [SW-1:0]  result;
    logic           out_valid_reg;
    logic [SW-1:0]  sample_out_reg;

    // ---------------- control ----------------
    assign adv       = !(out_valid_reg && out_stall);
    assign norm_busy = pend_reg || inflight_reg || recip_busy;
    assign in_stall  = !adv || norm_busy || cfg_valid;
    assign cfg_ready = !norm_busy && (occ_reg == '0);
    assign accept    = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign inject    = pend_reg && adv;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign recip_start = f2_valid_reg && f2_side_reg.is_norm && adv;

    always_comb
    begin
        pend_next     = pend_reg;
        inflight_next = inflight_reg;
        if (inject)
            pend_next = 1'b0;
        if (cfg_wr && (cfg_index == REG_STRETCH))
            pend_next = 1'b1;
        if (inject)
            inflight_next = 1'b1;
        else if (recip_start)
            inflight_next = 1'b0;
        // sample requests in the row
        occ_next = occ_reg;
        if (accept && !out_take)
            occ_next = occ_reg + OCW'(1);
        else if (!accept && out_take)
            occ_next = occ_reg - OCW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= 1'b1;
            inflight_reg <= 1'b0;
            occ_reg      <= '0;
            black_reg    <= '0;
            stretch_reg  <= SFW'(2560);
            gain_reg     <= GW'(256);
        end
        else
        begin
            pend_reg     <= pend_next;
            inflight_reg <= inflight_next;
            occ_reg      <= occ_next;
            if (cfg_wr)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_BLACK:   black_reg   <= cfg_data[BLW-1:0];
                    REG_STRETCH: stretch_reg <= cfg_data;
                    REG_GAIN:    gain_reg    <= cfg_data[GW-1:0];
                    default:     ;
                endcase
            end
        end
    end

    asp_recip u_recip (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (recip_start),
        .a_in     (a_reg),
        .busy     (recip_busy),
        .inv_norm (inv_norm)
    );

    // ---------------- front end ----------------
    always_comb
    begin
        bp_wide = ({16'd0, black_reg} << BP_LSH) >> BP_RSH;
        bp      = bp_wide[SAMPLE_BITS-1:0];
        diff    = sample_in - {1'b0, bp};
        side0   = '0;
        if (sample_in <= {1'b0, bp})
            side0.kind = KIND_ZERO;
        else if (sample_in[SAMPLE_BITS] && (stretch_reg[SFW-1:8] == '0))
            side0.kind = KIND_ONE;
        else
            side0.kind = KIND_CALC;
        if (inject)
        begin
            // beta token: x = 1.0 makes y = beta in Q.20
            side0.is_norm = 1'b1;
            side0.kind    = KIND_CALC;
            num0          = QW'(1) << 20;
            den0          = DW'(1);
        end
        else
        begin
            num0 = QW'(diff) << 20;
            den0 = ONE_S - {1'b0, bp};
        end
    end

    assign dv_valid[0] = accept || inject;
    assign dv_side[0]  = side0;
    assign dv_num[0]   = num0;
    assign dv_den[0]   = den0;
    assign dv_rem[0]   = '0;
    assign dv_quo[0]   = '0;

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        asp_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .valid_in  (dv_valid[i]),
            .side_in   (dv_side[i]),
            .num_in    (dv_num[i]),
            .den_in    (dv_den[i]),
            .rem_in    (dv_rem[i]),
            .quo_in    (dv_quo[i]),
            .valid_out (dv_valid[i+1]),
            .side_out  (dv_side[i+1]),
            .num_out   (dv_num[i+1]),
            .den_out   (dv_den[i+1]),
            .rem_out   (dv_rem[i+1]),
            .quo_out   (dv_quo[i+1])
        );
    end

    // ---------------- y = x * beta, two partial products ----------------
    assign y_full = ((YW+9)'(phi_reg) << XLO) + (YW+9)'(plo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_valid_reg <= dv_valid[QW];
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_side_reg <= dv_side[QW];
            plo_reg     <= dv_quo[QW][XLO-1:0] * stretch_reg;
            phi_reg     <= dv_quo[QW][QW-1:XLO] * stretch_reg;
            m2_side_reg <= m1_side_reg;
            y_reg       <= y_full[YW+7:8];
        end
    end

    // ---------------- root row ----------------
    assign sq_valid[0] = m2_valid_reg;
    assign sq_side[0]  = m2_side_reg;
    assign sq_y[0]     = YCW'(y_reg);
    assign sq_d[0]     = '0;
    assign sq_r[0]     = RMW'(1) << 40;

    for (genvar j = 0; j < SQB; j++)
    begin : g_sqrt
        asp_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .bit_idx   (SQIW'(SQB - 1 - j)),
            .valid_in  (sq_valid[j]),
            .side_in   (sq_side[j]),
            .y_in      (sq_y[j]),
            .d_in      (sq_d[j]),
            .r_in      (sq_r[j]),
            .valid_out (sq_valid[j+1]),
            .side_out  (sq_side[j+1]),
            .y_out     (sq_y[j+1]),
            .d_out     (sq_d[j+1]),
            .r_out     (sq_r[j+1])
        );
    end

    // ---------------- normalizer row ----------------
    assign nm_valid[0] = sq_valid[SQB];
    assign nm_side[0]  = sq_side[SQB];
    assign nm_word[0]  = (WW'(sq_y[SQB]) << 1) + WW'(sq_d[SQB]);
    assign nm_lz[0]    = '0;

    for (genvar k = 0; k < LZB; k++)
    begin : g_norm
        asp_norm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .shamt     (LZB'(1) << (LZB - 1 - k)),
            .valid_in  (nm_valid[k]),
            .side_in   (nm_side[k]),
            .word_in   (nm_word[k]),
            .lz_in     (nm_lz[k]),
            .valid_out (nm_valid[k+1]),
            .side_out  (nm_side[k+1]),
            .word_out  (nm_word[k+1]),
            .lz_out    (nm_lz[k+1])
        );
    end

    // ---------------- log row ----------------
    assign msb_pos = LZB'(WW - 1) - nm_lz[LZB];

    always_comb
    begin
        lg_side0         = nm_side[LZB];
        lg_side0.low_log = (msb_pos < LZB'(20));
        lg_side0.ipart   = msb_pos - LZB'(20);
    end

    assign lg_side[0]  = lg_side0;
    assign lg_valid[0] = nm_valid[LZB];
    assign lg_m[0]     = nm_word[LZB][WW-1 -: MW];
    assign lg_f[0]     = '0;

    for (genvar s = 0; s < ASINH_STAGES; s++)
    begin : g_log
        asp_log_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .valid_in  (lg_valid[s]),
            .side_in   (lg_side[s]),
            .m_in      (lg_m[s]),
            .f_in      (lg_f[s]),
            .valid_out (lg_valid[s+1]),
            .side_out  (lg_side[s+1]),
            .m_out     (lg_m[s+1]),
            .f_out     (lg_f[s+1])
        );
    end

    // ---------------- scaling and output ----------------
    assign r_scaled = m2p_reg[PW-1:OSH];

    always_comb
    begin
        unique case (f4_side_reg.kind)
            KIND_ZERO: result = '0;
            KIND_ONE:  result = ONE_S;
            default:   result = (r_scaled > (PW-OSH)'(ONE_S)) ? ONE_S : r_scaled[SW-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            f3_valid_reg  <= 1'b0;
            f4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_valid_reg  <= lg_valid[ASINH_STAGES];
            f2_valid_reg  <= f1_valid_reg;
            // beta token ends at the reciprocal unit
            f3_valid_reg  <= f2_valid_reg && !f2_side_reg.is_norm;
            f4_valid_reg  <= f3_valid_reg;
            out_valid_reg <= f4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_side_reg    <= lg_side[ASINH_STAGES];
            lp_reg         <= {lg_side[ASINH_STAGES].ipart, lg_f[ASINH_STAGES]} * LN2_Q24;
            f2_side_reg    <= f1_side_reg;
            a_reg          <= f1_side_reg.low_log ? '0 : lp_reg[LPW-1:ASINH_STAGES+4];
            f3_side_reg    <= f2_side_reg;
            m1p_reg        <= a_reg * inv_norm;
            f4_side_reg    <= f3_side_reg;
            m2p_reg        <= m1p_reg * gain_reg;
            sample_out_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

endmodule

FILE: design/asp_checker.sv
// ----------------------------------------------------------------------------
// asp_checker: port-level checks of the arcsinh stretch block
// Watches the sample and config channels over time.
// ----------------------------------------------------------------------------
module asp_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [asp_pkg::SW-1:0]  sample_out,
    input logic                    cfg_valid,
    input logic                    cfg_ready,
    input logic [asp_pkg::CIW-1:0] cfg_index
);
    import asp_pkg::*;

    // a result waiting on the output is held
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_out))
        else $error("stalled result changed");

    // results never exceed 1.0
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample_out <= ONE_S)
        else $error("result above 1.0");

    // a sample in flight holds off config
    a_cfg_wait: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !cfg_ready)
        else $error("config accepted with a sample in flight");

    // a blocked output backs up the input
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("sample taken while output blocked");

    // a stretch_factor write starts a new normalization
    a_beta_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index == REG_STRETCH) |=> !cfg_ready && in_stall)
        else $error("beta write did not block the block");

endmodule

bind asinh_stretch_pixel asp_checker u_asp_checker (.*);
